/* rtl/lfp_pkg.sv */
// ----------------------------------------------------------------------------
// lfp_pkg
// Shared types, constants and the X.25 CRC byte update for the frame parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lfp_pkg;

  localparam int unsigned HEADER_BYTES = 9;

  // header byte positions
  localparam int unsigned HDR_LEN    = 0;
  localparam int unsigned HDR_INCOMP = 1;
  localparam int unsigned HDR_SYS    = 4;
  localparam int unsigned HDR_COMP   = 5;
  localparam int unsigned HDR_ID0    = 6;
  localparam int unsigned HDR_ID1    = 7;
  localparam int unsigned HDR_ID2    = 8;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_START_BYTE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KNOWN_ID_A = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EXTRA_A    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KNOWN_ID_B = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_EXTRA_B    = 3'd4;

  localparam logic [7:0]  START_BYTE_RST = 8'd253;
  localparam logic [23:0] KNOWN_ID_A_RST = 24'd0;
  localparam logic [7:0]  EXTRA_A_RST    = 8'd50;
  localparam logic [23:0] KNOWN_ID_B_RST = 24'd253;
  localparam logic [7:0]  EXTRA_B_RST    = 8'd83;

  localparam logic [15:0] CRC_SEED = 16'hFFFF;

  localparam logic       KIND_DATA    = 1'b0;
  localparam logic       KIND_VERDICT = 1'b1;

  localparam logic [1:0] VERDICT_OK      = 2'd0;
  localparam logic [1:0] VERDICT_BAD_CRC = 2'd1;
  localparam logic [1:0] VERDICT_UNKNOWN = 2'd2;

  typedef struct packed {
    logic [7:0]  start_byte;
    logic [23:0] known_id_a;
    logic [7:0]  extra_a;
    logic [23:0] known_id_b;
    logic [7:0]  extra_b;
  } cfg_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  data_byte;
    logic [1:0]  verdict;
    logic [23:0] message_id;
    logic [7:0]  sender_system;
    logic [7:0]  sender_component;
    logic [7:0]  payload_length;
  } result_t;

  // one byte of the X.25 (CRC-16/MCRF4XX) update
  function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
    logic [7:0] t;
    t = b ^ crc[7:0];
    t = t ^ {t[3:0], 4'h0};
    return {8'h00, crc[15:8]} ^ {t, 8'h00} ^ {5'h00, t, 3'h0} ^ {12'h000, t[7:4]};
  endfunction

endpackage

/* rtl/lfp_byte_if.sv */
// ----------------------------------------------------------------------------
// lfp_byte_if
// Received byte channel: valid/ready with one serial byte per word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface lfp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

/* rtl/lfp_result_if.sv */
// ----------------------------------------------------------------------------
// lfp_result_if
// Result channel: payload bytes passed on and frame verdicts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface lfp_result_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  data_byte;
  logic [1:0]  verdict;
  logic [23:0] message_id;
  logic [7:0]  sender_system;
  logic [7:0]  sender_component;
  logic [7:0]  payload_length;

  modport source (output valid, output kind, output data_byte, output verdict,
                  output message_id, output sender_system, output sender_component,
                  output payload_length, input ready);
  modport sink   (input valid, input kind, input data_byte, input verdict,
                  input message_id, input sender_system, input sender_component,
                  input payload_length, output ready);
endinterface

/* rtl/lfp_cfg_if.sv */
// ----------------------------------------------------------------------------
// lfp_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface lfp_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  reg_index;
  logic [23:0] wr_data;

  modport source (output valid, output reg_index, output wr_data, input ready);
  modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

/* rtl/lfp_cfg_regs.sv */
// ----------------------------------------------------------------------------
// lfp_cfg_regs
// Configuration register file: start byte and the two id/extra pairs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lfp_cfg_regs (
  input  logic          clk_i,
  input  logic          rst_ni,
  lfp_cfg_if.sink       cfg_i,
  output lfp_pkg::cfg_t cfg_o
);

  lfp_pkg::cfg_t cfg_q, cfg_d;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      case (cfg_i.reg_index)
        lfp_pkg::CFG_START_BYTE: cfg_d.start_byte = cfg_i.wr_data[7:0];
        lfp_pkg::CFG_KNOWN_ID_A: cfg_d.known_id_a = cfg_i.wr_data;
        lfp_pkg::CFG_EXTRA_A:    cfg_d.extra_a    = cfg_i.wr_data[7:0];
        lfp_pkg::CFG_KNOWN_ID_B: cfg_d.known_id_b = cfg_i.wr_data;
        lfp_pkg::CFG_EXTRA_B:    cfg_d.extra_b    = cfg_i.wr_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_byte <= lfp_pkg::START_BYTE_RST;
      cfg_q.known_id_a <= lfp_pkg::KNOWN_ID_A_RST;
      cfg_q.extra_a    <= lfp_pkg::EXTRA_A_RST;
      cfg_q.known_id_b <= lfp_pkg::KNOWN_ID_B_RST;
      cfg_q.extra_b    <= lfp_pkg::EXTRA_B_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* rtl/lfp_parser.sv */
// ----------------------------------------------------------------------------
// lfp_parser
// Input byte register and frame state machine with running CRC.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lfp_parser #(
  parameter int unsigned SIGNATURE_BYTES = 13
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  lfp_byte_if.sink         rx_i,
  input  lfp_pkg::cfg_t    cfg_i,
  input  logic             out_free_i,
  output logic             res_valid_o,
  output lfp_pkg::result_t res_o
);

  localparam int unsigned SIG_W = $clog2(SIGNATURE_BYTES + 1);
  localparam int unsigned HIDX_W = $clog2(lfp_pkg::HEADER_BYTES);
  localparam logic [SIG_W-1:0] SIG_LAST = SIG_W'(SIGNATURE_BYTES);
  localparam logic [HIDX_W-1:0] HIDX_LAST = HIDX_W'(lfp_pkg::HEADER_BYTES - 1);

  typedef enum logic [2:0] {
    PH_WAIT, PH_HEADER, PH_PAYLOAD, PH_CRC1, PH_CRC2, PH_SIG
  } phase_e;

  // input register
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       adv;

  phase_e              phase_q, phase_d;
  logic [HIDX_W-1:0]   hidx_q, hidx_d;
  logic [7:0]          pcnt_q, pcnt_d;
  logic                signed_q, signed_d;
  logic [SIG_W-1:0]    scnt_q, scnt_d;
  logic [15:0]         crc_q, crc_d;
  logic [15:0]         rcrc_q, rcrc_d;
  logic [7:0]          hdr_q [lfp_pkg::HEADER_BYTES];
  logic                hdr_we;

  logic [23:0] cur_id;
  logic [15:0] rcrc_final;
  logic [15:0] crc_a, crc_b;
  logic [1:0]  verdict;
  logic        emit, emit_verdict;

  assign adv = in_valid_q && out_free_i;
  assign rx_i.ready = !in_valid_q || adv;

  assign cur_id = {hdr_q[lfp_pkg::HDR_ID2], hdr_q[lfp_pkg::HDR_ID1], hdr_q[lfp_pkg::HDR_ID0]};

  // in the second checksum state the high byte is still on the input
  assign rcrc_final = (phase_q == PH_CRC2) ? {in_byte_q, rcrc_q[7:0]} : rcrc_q;
  assign crc_a = lfp_pkg::crc_fold(crc_q, cfg_i.extra_a);
  assign crc_b = lfp_pkg::crc_fold(crc_q, cfg_i.extra_b);

  always_comb begin
    if (cur_id == cfg_i.known_id_a) begin
      verdict = (crc_a == rcrc_final) ? lfp_pkg::VERDICT_OK : lfp_pkg::VERDICT_BAD_CRC;
    end else if (cur_id == cfg_i.known_id_b) begin
      verdict = (crc_b == rcrc_final) ? lfp_pkg::VERDICT_OK : lfp_pkg::VERDICT_BAD_CRC;
    end else begin
      verdict = lfp_pkg::VERDICT_UNKNOWN;
    end
  end

  always_comb begin
    phase_d      = phase_q;
    hidx_d       = hidx_q;
    pcnt_d       = pcnt_q;
    signed_d     = signed_q;
    scnt_d       = scnt_q;
    crc_d        = crc_q;
    rcrc_d       = rcrc_q;
    hdr_we       = 1'b0;
    emit         = 1'b0;
    emit_verdict = 1'b0;
    case (phase_q)
      PH_HEADER: begin
        hdr_we = 1'b1;
        crc_d  = lfp_pkg::crc_fold(crc_q, in_byte_q);
        hidx_d = hidx_q + 1'b1;
        if (hidx_q == HIDX_LAST) begin
          pcnt_d   = '0;
          signed_d = hdr_q[lfp_pkg::HDR_INCOMP][0];
          phase_d  = (hdr_q[lfp_pkg::HDR_LEN] != 8'd0) ? PH_PAYLOAD : PH_CRC1;
        end
      end
      PH_PAYLOAD: begin
        crc_d  = lfp_pkg::crc_fold(crc_q, in_byte_q);
        pcnt_d = pcnt_q + 1'b1;
        if (pcnt_d == hdr_q[lfp_pkg::HDR_LEN]) begin
          phase_d = PH_CRC1;
        end
        emit = 1'b1;
      end
      PH_CRC1: begin
        rcrc_d  = {8'h00, in_byte_q};
        phase_d = PH_CRC2;
      end
      PH_CRC2: begin
        rcrc_d = rcrc_final;
        if (signed_q) begin
          scnt_d  = '0;
          phase_d = PH_SIG;
        end else begin
          emit         = 1'b1;
          emit_verdict = 1'b1;
          phase_d      = PH_WAIT;
        end
      end
      PH_SIG: begin
        scnt_d = scnt_q + 1'b1;
        if (scnt_d == SIG_LAST) begin
          emit         = 1'b1;
          emit_verdict = 1'b1;
          phase_d      = PH_WAIT;
        end
      end
      default: begin
        phase_d = PH_WAIT;
        if (in_byte_q == cfg_i.start_byte) begin
          hidx_d  = '0;
          crc_d   = lfp_pkg::CRC_SEED;
          phase_d = PH_HEADER;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      phase_q    <= PH_WAIT;
      hidx_q     <= '0;
      pcnt_q     <= '0;
      signed_q   <= 1'b0;
      scnt_q     <= '0;
      crc_q      <= lfp_pkg::CRC_SEED;
      rcrc_q     <= '0;
    end else begin
      if (rx_i.ready) begin
        in_valid_q <= rx_i.valid;
      end
      if (adv) begin
        phase_q  <= phase_d;
        hidx_q   <= hidx_d;
        pcnt_q   <= pcnt_d;
        signed_q <= signed_d;
        scnt_q   <= scnt_d;
        crc_q    <= crc_d;
        rcrc_q   <= rcrc_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_i.valid && rx_i.ready) begin
      in_byte_q <= rx_i.rx_byte;
    end
    if (adv && hdr_we) begin
      hdr_q[hidx_q] <= in_byte_q;
    end
  end

  assign res_valid_o = adv && emit;

  always_comb begin
    res_o.kind             = emit_verdict ? lfp_pkg::KIND_VERDICT : lfp_pkg::KIND_DATA;
    res_o.data_byte        = emit_verdict ? 8'h00 : in_byte_q;
    res_o.verdict          = emit_verdict ? verdict : lfp_pkg::VERDICT_OK;
    res_o.message_id       = cur_id;
    res_o.sender_system    = hdr_q[lfp_pkg::HDR_SYS];
    res_o.sender_component = hdr_q[lfp_pkg::HDR_COMP];
    res_o.payload_length   = hdr_q[lfp_pkg::HDR_LEN];
  end

endmodule

/* rtl/lfp_out_reg.sv */
// ----------------------------------------------------------------------------
// lfp_out_reg
// Result register driving the output channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lfp_out_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             res_valid_i,
  input  lfp_pkg::result_t res_i,
  output logic             out_free_o,
  lfp_result_if.source     res_o
);

  logic             valid_q;
  lfp_pkg::result_t data_q;

  assign out_free_o = !valid_q || res_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (out_free_o) begin
      valid_q <= res_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free_o && res_valid_i) begin
      data_q <= res_i;
    end
  end

  assign res_o.valid            = valid_q;
  assign res_o.kind             = data_q.kind;
  assign res_o.data_byte        = data_q.data_byte;
  assign res_o.verdict          = data_q.verdict;
  assign res_o.message_id       = data_q.message_id;
  assign res_o.sender_system    = data_q.sender_system;
  assign res_o.sender_component = data_q.sender_component;
  assign res_o.payload_length   = data_q.payload_length;

endmodule

/* rtl/link_frame_parser_crc_check_top.sv */
// ----------------------------------------------------------------------------
// link_frame_parser_crc_check_top
// Byte-wise link frame parser with X.25 CRC check and payload pass-through.
// ----------------------------------------------------------------------------
//  channel | dir | handshake   | word
//  rx_i    | in  | valid/ready | rx_byte
//  res_o   | out | valid/ready | kind, data_byte, verdict, id, system, component, length
//  cfg_i   | in  | valid/ready | reg_index, wr_data (always ready)
//
//  One byte per cycle sustained while res_o is not stalled; a result reaches
//  res_o through the input register, then the result register.
//  Reset is asynchronous, active low; config regs return to their defaults.
//  A stalled result holds the result register and the parser; the input register
//  takes a byte only while it is empty, else rx_i.ready drops until res_o is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module link_frame_parser_crc_check_top #(
  parameter int unsigned SIGNATURE_BYTES = 13
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  lfp_byte_if.sink     rx_i,
  lfp_result_if.source res_o,
  lfp_cfg_if.sink      cfg_i
);

  lfp_pkg::cfg_t    cfg;
  lfp_pkg::result_t res;
  logic             res_valid;
  logic             out_free;

  lfp_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  lfp_parser #(
    .SIGNATURE_BYTES (SIGNATURE_BYTES)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rx_i        (rx_i),
    .cfg_i       (cfg),
    .out_free_i  (out_free),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  lfp_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .out_free_o  (out_free),
    .res_o       (res_o)
  );

endmodule
